[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the responder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An antecedent that forces a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/dwar_pkg.sv]
// ----------------------------------------------------------------------------
// dwar_pkg
// Types, constants and reply item generation shared by the responder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dwar_pkg;

    // Longest question name that is copied into the reply.
    localparam logic [7:0] NAME_MAX_BYTES = 8'd255;

    // Configuration register indexes.
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_ADDRESS = 1'b1;

    // Width of the per-job item counter (up to 21 items).
    localparam int IDX_W = 5;

    // Job kinds handed from the parser to the emitter.
    localparam logic [2:0] JOB_NONE = 3'd0;
    localparam logic [2:0] JOB_ECHO = 3'd1;
    localparam logic [2:0] JOB_HEAD = 3'd2;
    localparam logic [2:0] JOB_TAIL = 3'd3;
    localparam logic [2:0] JOB_ERR  = 3'd4;

    // Item indexes and lengths within multi-item jobs.
    localparam logic [IDX_W-1:0] HEAD_LAST  = 5'd10;
    localparam logic [IDX_W-1:0] TAIL_LAST  = 5'd20;
    localparam logic [IDX_W-1:0] TRAIL_END  = 5'd16;
    localparam logic [IDX_W-1:0] ADDR_FIRST = 5'd17;
    localparam logic [IDX_W-1:0] HDR_FIXED_BYTES = 5'd10;

    // Fixed reply header after the identifier: flags, counts.
    localparam logic [7:0] HEADER_BYTES [10] = '{
        8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Fixed trailer: qtype, qclass, name pointer, type, class, TTL, length.
    localparam logic [7:0] TRAILER_BYTES [16] = '{
        8'h00, 8'h01, 8'h00, 8'h01, 8'hC0, 8'h0C, 8'h00, 8'h01,
        8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h78, 8'h00, 8'h04
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
    } job_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       error;
    } item_t;

    // Index of the final item of a job.
    function automatic logic [IDX_W-1:0] job_last_idx(input logic [2:0] kind);
        logic [IDX_W-1:0] res;
        res = '0;
        case (kind)
            JOB_HEAD: res = HEAD_LAST;
            JOB_TAIL: res = TAIL_LAST;
            default:  res = '0;
        endcase
        return res;
    endfunction

    // Reply item number idx of a job.
    function automatic item_t make_item(input job_t job, input logic [IDX_W-1:0] idx,
                                        input logic [31:0] addr);
        item_t            it;
        logic [IDX_W-1:0] off;
        logic [IDX_W-1:0] aoff;
        it   = '0;
        off  = idx - IDX_W'(1);
        aoff = idx - ADDR_FIRST;
        case (job.kind)
            JOB_ECHO: it.value = job.value;
            JOB_HEAD:
            begin
                if (idx == '0)
                    it.value = job.value;
                else if (off < HDR_FIXED_BYTES)
                    it.value = HEADER_BYTES[off[3:0]];
            end
            JOB_TAIL:
            begin
                if (idx == '0)
                    it.value = 8'h00;
                else if (idx <= TRAIL_END)
                    it.value = TRAILER_BYTES[off[3:0]];
                else
                begin
                    case (aoff[1:0])
                        2'd0:    it.value = addr[31:24];
                        2'd1:    it.value = addr[23:16];
                        2'd2:    it.value = addr[15:8];
                        default: it.value = addr[7:0];
                    endcase
                end
                it.last = (idx == TAIL_LAST);
            end
            JOB_ERR:
            begin
                it.last  = 1'b1;
                it.error = 1'b1;
            end
            default: it = '0;
        endcase
        return it;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dwar_if.sv]
// ----------------------------------------------------------------------------
// Responder channels
// Query byte channel and reply item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// Query bytes into the responder.
interface dwar_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Reply items out of the responder.
interface dwar_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/dwar_parser.sv]
// ----------------------------------------------------------------------------
// dwar_parser
// Tracks the position in the query packet and turns each byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module dwar_parser
    import dwar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enable,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       accept,
    output job_t       job
);

    localparam logic [1:0] PH_HEAD  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    localparam logic [3:0] POS_ID_LO  = 4'd0;
    localparam logic [3:0] POS_ID_HI  = 4'd1;
    localparam logic [3:0] POS_HDR_END = 4'd11;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] name_len_reg, name_len_next;

    // Job and next parser state for the byte on the input.
    always_comb
    begin
        job           = '{kind: JOB_NONE, value: in_byte};
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        name_len_next = name_len_reg;

        if (!enable)
        begin
            if (in_last)
            begin
                phase_next    = PH_HEAD;
                pos_next      = '0;
                name_len_next = '0;
            end
            else
                phase_next = PH_DRAIN;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    if (in_last)
                    begin
                        job.kind      = JOB_ERR;
                        pos_next      = '0;
                        name_len_next = '0;
                    end
                    else
                    begin
                        if (pos_reg == POS_ID_LO)
                            job.kind = JOB_ECHO;
                        else if (pos_reg == POS_ID_HI)
                            job.kind = JOB_HEAD;
                        if (pos_reg == POS_HDR_END)
                        begin
                            pos_next      = '0;
                            name_len_next = '0;
                            phase_next    = PH_NAME;
                        end
                        else
                            pos_next = pos_reg + 4'd1;
                    end
                end
                PH_NAME:
                begin
                    if (in_byte == 8'h00 || in_last || name_len_reg >= NAME_MAX_BYTES)
                    begin
                        job.kind = (in_byte == 8'h00) ? JOB_TAIL : JOB_ERR;
                        if (in_last)
                        begin
                            phase_next    = PH_HEAD;
                            pos_next      = '0;
                            name_len_next = '0;
                        end
                        else
                            phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        job.kind      = JOB_ECHO;
                        name_len_next = name_len_reg + 8'd1;
                    end
                end
                default:
                begin
                    // Drain, and the unused phase code behaves the same.
                    if (in_last)
                    begin
                        phase_next    = PH_HEAD;
                        pos_next      = '0;
                        name_len_next = '0;
                    end
                end
            endcase
        end
    end

    // Parser state advances on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            pos_reg      <= '0;
            name_len_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            name_len_reg <= name_len_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwar_emitter.sv]
// ----------------------------------------------------------------------------
// dwar_emitter
// Holds one job and plays its reply items, one per cycle while the output
// register is empty or being taken, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwar_emitter
    import dwar_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          job,
    input  logic          job_load,
    input  logic [31:0]   answer_address,
    output logic          job_ready,
    dwar_reply_if.source  reply
);

    job_t             job_reg;
    logic             job_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    item_t            out_reg;
    item_t            item_next;
    logic             advance;
    logic             job_done;

    // One item moves into the output register when it is empty or being taken.
    assign advance   = job_valid_reg && (!out_valid_reg || reply.ready);
    assign job_done  = advance && (idx_reg == job_last_idx(job_reg.kind));
    assign job_ready = !job_valid_reg || job_done;
    assign item_next = make_item(job_reg, idx_reg, answer_address);

    // Job slot and item counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= (job.kind != JOB_NONE);
            idx_reg       <= '0;
        end
        else if (job_done)
            job_valid_reg <= 1'b0;
        else if (advance)
            idx_reg <= idx_reg + IDX_W'(1);
    end

    // Job payload.
    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (reply.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= item_next;
    end

    assign reply.valid     = out_valid_reg;
    assign reply.out_byte  = out_reg.value;
    assign reply.out_last  = out_reg.last;
    assign reply.out_error = out_reg.error;

endmodule

`default_nettype wire

[hw/rtl/dns_wildcard_answer_responder_core.sv]
// ----------------------------------------------------------------------------
// dns_wildcard_answer_responder_core
// Answers each DNS query, while enabled, with one configured IPv4 address.
// ----------------------------------------------------------------------------
// Query bytes enter on the query channel and reply items leave on the reply
// channel. A byte that yields at most one reply item is taken once the job
// slot frees, so identifier and name bytes stream at full rate unless the
// reply stalls. The second identifier byte holds the input for its 11 items
// and the name terminator for its 21, as the output register takes one item
// per cycle while empty or being taken. Items pass the job register, then
// the output register. Register 0 enables answering, register 1 holds the
// address sent most significant byte first; write them only while idle.
`default_nettype none

module dns_wildcard_answer_responder_core
    import dwar_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    dwar_query_if.sink   query,
    dwar_reply_if.source reply
);

    logic        enable_reg;
    logic [31:0] address_reg;
    logic        accept;
    logic        job_ready;
    job_t        job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            address_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                REG_ADDRESS: address_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // A query item is taken whenever the job slot frees up.
    assign query.ready = job_ready;
    assign accept      = query.valid && job_ready;

    dwar_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (enable_reg),
        .in_byte (query.in_byte),
        .in_last (query.in_last),
        .accept  (accept),
        .job     (job)
    );

    dwar_emitter u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (job),
        .job_load       (accept),
        .answer_address (address_reg),
        .job_ready      (job_ready),
        .reply          (reply)
    );

endmodule

`default_nettype wire

[hw/rtl/dwar_checker.sv]
// ----------------------------------------------------------------------------
// dwar_checker
// Port-level checks on the responder reply channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dwar_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       reply_valid,
    input logic       reply_ready,
    input logic [7:0] reply_out_byte,
    input logic       reply_out_last,
    input logic       reply_out_error
);

    logic [9:0] reply_item;
    logic       reply_stall;
    logic       reply_err;

    // Whole reply item and the conditions the checks key on.
    assign reply_item  = {reply_out_byte, reply_out_last, reply_out_error};
    assign reply_stall = reply_valid && !reply_ready;
    assign reply_err   = reply_valid && reply_out_error;

    // A stalled reply item holds.
    `ASSERT_NEXT(a_reply_hold, clk, rst_n, reply_stall, reply_valid && $stable(reply_item))

    // An error item is a zero byte and closes its run.
    `ASSERT_ALWAYS(a_error_form, clk, rst_n, reply_err |-> reply_out_last && !(|reply_out_byte))

    // Nothing is offered in the first cycle after reset.
    `ASSERT_ALWAYS(a_reset_quiet, clk, rst_n, $rose(rst_n) |-> !reply_valid)

endmodule

bind dns_wildcard_answer_responder_core dwar_checker u_dwar_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .reply_valid     (reply.valid),
    .reply_ready     (reply.ready),
    .reply_out_byte  (reply.out_byte),
    .reply_out_last  (reply.out_last),
    .reply_out_error (reply.out_error)
);

`default_nettype wire
